// ----- src/multicore_interrupt_distributor_unit_macros.svh -----
// Assertion macros for the interrupt distributor checker.
`ifndef MULTICORE_INTERRUPT_DISTRIBUTOR_UNIT_MACROS_SVH
`define MULTICORE_INTERRUPT_DISTRIBUTOR_UNIT_MACROS_SVH

// Implication in the next cycle.
`define MCID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Implication in the same cycle.
`define MCID_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/mcid_pkg.sv -----
// Shared types, codes and helpers of the interrupt distributor.
`default_nettype none
package mcid_pkg;
	localparam int MAXC = 4;
	localparam int MAXB = 4;
	localparam int NUM_CORES_DEF = 4;
	localparam int NUM_LINES_DEF = 128;
	localparam logic [11:0] NONE_ID = 12'h3FF;

	typedef enum logic [3:0] {
		F_RAISE = 4'd0,
		F_ENSET = 4'd1,
		F_ENCLR = 4'd2,
		F_PSET  = 4'd3,
		F_PCLR  = 4'd4,
		F_TGTWR = 4'd5,
		F_GEN   = 4'd6,
		F_LEN   = 4'd7,
		F_SOFT  = 4'd8,
		F_ACK   = 4'd9,
		F_PEEK  = 4'd10,
		F_EOI   = 4'd11
	} func_t;

	typedef struct packed {
		logic [3:0]  func;
		logic [1:0]  core;
		logic [6:0]  index;
		logic [31:0] wdata;
		logic [31:0] wmask;
	} req_t;

	typedef struct packed {
		logic [11:0] rdata;
		logic [3:0]  irq_lines;
		logic        error;
	} rsp_t;

	typedef struct packed {
		logic pend_we;
		logic tgt_we;
		logic src_we;
		logic err;
	} upd_ctl_t;

	function automatic logic [31:0] line_mask(input logic [1:0] bank, input int num_lines);
		logic [31:0] m;
		m = '0;
		for (int j = 0; j < 32; j++) begin
			m[j] = (int'(bank) * 32 + j) < num_lines;
		end
		return m;
	endfunction

	function automatic logic [4:0] lowest_set(input logic [31:0] w);
		logic [4:0] p;
		p = '0;
		for (int i = 31; i >= 0; i--) begin
			if (w[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction
endpackage
`default_nettype wire

// ----- src/mcid_upd.sv -----
// Row update logic for pending, target and soft-source rows of one bank.
`default_nettype none
module mcid_upd #(
	parameter int NUM_CORES = mcid_pkg::NUM_CORES_DEF,
	parameter int NUM_LINES = mcid_pkg::NUM_LINES_DEF
) (
	input  mcid_pkg::req_t     req,
	input  logic [1:0]         bank,
	input  logic [127:0]       prow,
	input  logic [127:0]       trow,
	input  logic [7:0]         srow,
	input  logic               glob,
	input  logic [3:0]         loc,
	output logic [127:0]       prow_new,
	output logic [127:0]       trow_new,
	output logic [7:0]         srow_new,
	output mcid_pkg::upd_ctl_t ctl
);
	import mcid_pkg::*;

	localparam int NBANK = (NUM_LINES + 31) / 32;

	logic [31:0] v;
	logic [31:0] cm;
	logic [31:0] lmask;
	logic        core_ok;
	logic        bank_ok;
	logic        line_ok;
	logic [3:0]  dest;
	logic [4:0]  j5;
	logic [3:0]  ty;

	function automatic logic tgt(input logic [127:0] t, input logic [1:0] b,
			input int c, input logic [4:0] j);
		logic r;
		if (b == 2'd0 && j >= 5'd29) begin
			r = 1'b1;
		end else begin
			r = t[int'(j) * 4 + c];
		end
		return r;
	endfunction

	assign v = req.wdata & req.wmask;
	assign cm = (req.index == 7'd0) ? (v & 32'hFFFF_0000) : v;
	assign lmask = line_mask(bank, NUM_LINES);
	assign core_ok = {1'b0, req.core} < 3'(NUM_CORES);
	assign bank_ok = {1'b0, req.index} < 8'(NBANK);
	assign line_ok = {1'b0, req.index} < 8'(NUM_LINES);
	assign j5 = req.index[4:0];
	assign ty = v[3:0];

	always_comb begin
		prow_new = prow;
		trow_new = trow;
		srow_new = srow;
		ctl = '0;
		dest = '0;
		case (req.func)
			F_RAISE: begin
				if (glob && line_ok) begin
					for (int c = 0; c < MAXC; c++) begin
						if (c < NUM_CORES && loc[c] && tgt(trow, bank, c, j5)) begin
							prow_new[c * 32 + int'(j5)] = 1'b1;
						end
					end
					ctl.pend_we = 1'b1;
				end
			end
			F_PSET: begin
				if (bank_ok) begin
					for (int j = 0; j < 32; j++) begin
						for (int c = 0; c < MAXC; c++) begin
							if (v[j] && lmask[j] && c < NUM_CORES
									&& tgt(trow, bank, c, 5'(j))) begin
								prow_new[c * 32 + j] = 1'b1;
							end
						end
					end
					ctl.pend_we = 1'b1;
				end
			end
			F_PCLR: begin
				if (bank_ok) begin
					for (int c = 0; c < MAXC; c++) begin
						prow_new[c * 32 +: 32] = prow[c * 32 +: 32] & ~cm;
					end
					ctl.pend_we = 1'b1;
				end
			end
			F_TGTWR: begin
				if (req.index >= 7'd32 && line_ok) begin
					trow_new[int'(j5) * 4 +: 4] = (trow[int'(j5) * 4 +: 4] & ~req.wmask[3:0])
						| (req.wdata[3:0] & req.wmask[3:0]);
					ctl.tgt_we = 1'b1;
				end
			end
			F_SOFT: begin
				if (core_ok) begin
					if (v[8:0] >= 9'd16 || v[25:24] == 2'd3) begin
						ctl.err = 1'b1;
					end else begin
						priority case (v[25:24])
							2'd0: dest = v[19:16];
							2'd1: dest = ~(4'd1 << req.core);
							default: dest = 4'd1 << req.core;
						endcase
						if (glob) begin
							for (int c = 0; c < MAXC; c++) begin
								if (dest[c] && loc[c] && c < NUM_CORES) begin
									prow_new[c * 32 + int'(ty)] = 1'b1;
									srow_new[c * 2 +: 2] = req.core;
								end
							end
							ctl.pend_we = 1'b1;
							ctl.src_we = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- src/multicore_interrupt_distributor_unit.sv -----
// Interrupt distributor top level: sequencer, bank memories and enable state.
// Usage:
//   Request channel req (req_valid/req_stall) carries one bus access or one
//   hardware raise per beat; response channel rsp (rsp_valid/rsp_stall) returns
//   exactly one beat per request with rdata, irq_lines and error.
//   Pending rows, target rows and soft-source rows live in synchronous memories
//   with registered read data; each request reads its bank row, and those that
//   update it write it back.
//   Each request steps through exec and done states; ack and peek scan one bank
//   per cycle, moving on to the next bank while no hit is found, and add a
//   source lookup step for lines below 16. One request is in flight at a time:
//   req_stall stays high until its response is registered.
//   Reset clears all enables directly, and pending rows, targets and sources
//   at once through per-row valid bits. No clearing pass is needed.
//   A stalled response holds in its output register; the next request is taken
//   meanwhile and waits in its final step until the register frees.
`default_nettype none
module multicore_interrupt_distributor_unit #(
	parameter int NUM_CORES = mcid_pkg::NUM_CORES_DEF,
	parameter int NUM_LINES = mcid_pkg::NUM_LINES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mcid_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mcid_pkg::rsp_t rsp
);
	import mcid_pkg::*;

	localparam int NBANK = (NUM_LINES + 31) / 32;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SRC  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                     state_q;
	req_t                       req_q;
	logic [1:0]                 bank_q;
	logic [11:0]                rdata_q;
	logic                       err_q;
	rsp_t                       rsp_q;
	logic                       rsp_valid_q;
	logic [MAXB-1:0][31:0]      en_q;
	logic                       glob_q;
	logic [MAXC-1:0]            loc_q;
	logic [MAXB-1:0][MAXC-1:0]  hit_q;

	logic [127:0] pend_mem [MAXB];
	logic [127:0] tgt_mem [MAXB];
	logic [7:0]   src_mem [16];
	logic [MAXB-1:0] pvld_q;
	logic [MAXB-1:0] tvld_q;
	logic [15:0]     svld_q;
	logic [127:0] pend_rd_q;
	logic [127:0] tgt_rd_q;
	logic [7:0]   src_rd_q;
	logic         pend_rv_q;
	logic         tgt_rv_q;
	logic         src_rv_q;

	logic [127:0] prow;
	logic [127:0] trow;
	logic [7:0]   srow;
	logic [127:0] prow_new;
	logic [127:0] trow_new;
	logic [7:0]   srow_new;
	upd_ctl_t     ctl;

	logic         accept;
	logic [1:0]   in_bank;
	logic [31:0]  v;
	logic [31:0]  cm;
	logic         core_ok;
	logic         bank_ok;
	logic         scan;
	logic [31:0]  hit;
	logic [4:0]   pos;
	logic [6:0]   line;
	logic         more;
	logic [127:0] prow_take;
	logic [31:0]  en_next;
	logic [127:0] pend_wd;
	logic         pend_we;
	logic         tgt_we;
	logic         src_we;
	logic [1:0]   pend_ra;
	logic [3:0]   src_ra;
	logic         take_wr;
	logic         hit_upd;
	logic [3:0]   irq;
	logic         out_free;

	assign accept = req_valid && !req_stall;
	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		priority case (req.func)
			F_RAISE, F_TGTWR: in_bank = req.index[6:5];
			F_ENSET, F_ENCLR, F_PSET, F_PCLR: in_bank = req.index[1:0];
			default: in_bank = 2'd0;
		endcase
	end

	assign prow = pend_rv_q ? pend_rd_q : '0;
	assign trow = tgt_rv_q ? tgt_rd_q : '0;
	assign srow = src_rv_q ? src_rd_q : '0;

	mcid_upd #(
		.NUM_CORES(NUM_CORES),
		.NUM_LINES(NUM_LINES)
	) u_upd (
		.req      (req_q),
		.bank     (bank_q),
		.prow     (prow),
		.trow     (trow),
		.srow     (srow),
		.glob     (glob_q),
		.loc      (loc_q),
		.prow_new (prow_new),
		.trow_new (trow_new),
		.srow_new (srow_new),
		.ctl      (ctl)
	);

	assign v = req_q.wdata & req_q.wmask;
	assign cm = (req_q.index == 7'd0) ? (v & 32'hFFFF_0000) : v;
	assign core_ok = {1'b0, req_q.core} < 3'(NUM_CORES);
	assign bank_ok = {1'b0, req_q.index} < 8'(NBANK);
	assign scan = req_q.func == F_ACK || req_q.func == F_PEEK;
	assign hit = en_q[bank_q] & prow[int'(req_q.core) * 32 +: 32] & line_mask(bank_q, NUM_LINES);
	assign pos = lowest_set(hit);
	assign line = {bank_q, pos};
	assign more = ({1'b0, bank_q} + 3'd1) < 3'(NBANK);

	always_comb begin
		prow_take = prow;
		prow_take[int'(req_q.core) * 32 + int'(pos)] = 1'b0;
	end

	always_comb begin
		en_next = en_q[bank_q];
		if (req_q.func == F_ENSET && bank_ok) begin
			en_next = en_q[bank_q] | v;
		end else if (req_q.func == F_ENCLR && bank_ok) begin
			en_next = en_q[bank_q] & ~cm;
		end
	end

	assign take_wr = state_q == ST_EXEC && scan && core_ok && (|hit)
		&& req_q.func == F_ACK;
	assign hit_upd = state_q == ST_EXEC && (!scan || take_wr);
	assign pend_we = take_wr || (state_q == ST_EXEC && !scan && ctl.pend_we);
	assign pend_wd = scan ? prow_take : prow_new;
	assign tgt_we = state_q == ST_EXEC && !scan && ctl.tgt_we;
	assign src_we = state_q == ST_EXEC && !scan && ctl.src_we;
	assign pend_ra = (state_q == ST_IDLE) ? in_bank : bank_q + 2'd1;
	assign src_ra = (state_q == ST_IDLE) ? (req.wdata[3:0] & req.wmask[3:0]) : pos[3:0];

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[bank_q] <= pend_wd;
		end
		pend_rd_q <= pend_mem[pend_ra];
		if (tgt_we) begin
			tgt_mem[bank_q] <= trow_new;
		end
		tgt_rd_q <= tgt_mem[in_bank];
		if (src_we) begin
			src_mem[v[3:0]] <= srow_new;
		end
		src_rd_q <= src_mem[src_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= '0;
			tvld_q <= '0;
			svld_q <= '0;
			pend_rv_q <= 1'b0;
			tgt_rv_q <= 1'b0;
			src_rv_q <= 1'b0;
		end else begin
			pend_rv_q <= pvld_q[pend_ra];
			tgt_rv_q <= tvld_q[in_bank];
			src_rv_q <= svld_q[src_ra];
			if (pend_we) begin
				pvld_q[bank_q] <= 1'b1;
			end
			if (tgt_we) begin
				tvld_q[bank_q] <= 1'b1;
			end
			if (src_we) begin
				svld_q[v[3:0]] <= 1'b1;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < MAXC; c++) begin
			irq[c] = 1'b0;
			for (int b = 0; b < MAXB; b++) begin
				irq[c] = irq[c] | hit_q[b][c];
			end
			irq[c] = irq[c] && glob_q && loc_q[c] && c < NUM_CORES;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bank_q <= '0;
			rdata_q <= '0;
			err_q <= 1'b0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
			en_q <= '0;
			glob_q <= 1'b0;
			loc_q <= '0;
			hit_q <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (hit_upd) begin
				en_q[bank_q] <= en_next;
				for (int c = 0; c < MAXC; c++) begin
					hit_q[bank_q][c] <= |(en_next & pend_wd[c * 32 +: 32]);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bank_q <= in_bank;
						rdata_q <= '0;
						err_q <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (scan) begin
						if (!core_ok) begin
							rdata_q <= NONE_ID;
							state_q <= ST_DONE;
						end else if (|hit) begin
							rdata_q <= {5'd0, line};
							state_q <= (line < 7'd16) ? ST_SRC : ST_DONE;
						end else if (more) begin
							bank_q <= bank_q + 2'd1;
						end else begin
							rdata_q <= NONE_ID;
							state_q <= ST_DONE;
						end
					end else begin
						err_q <= ctl.err;
						if (req_q.func == F_GEN && req_q.wmask[0]) begin
							glob_q <= req_q.wdata[0];
						end
						if (req_q.func == F_LEN && core_ok && req_q.wmask[0]) begin
							loc_q[req_q.core] <= req_q.wdata[0];
						end
						state_q <= ST_DONE;
					end
				end
				ST_SRC: begin
					rdata_q[11:10] <= srow[int'(req_q.core) * 2 +: 2];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_q <= '{rdata: rdata_q, irq_lines: irq, error: err_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/mcid_checker.sv -----
// Port-level checker for the interrupt distributor and its bind.
`default_nettype none
`include "multicore_interrupt_distributor_unit_macros.svh"
module mcid_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire mcid_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire mcid_pkg::rsp_t rsp
);
	import mcid_pkg::*;

	`MCID_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`MCID_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && !req_stall, req_stall)
	`MCID_ASSERT_SAME(a_err_no_rdata, clk, arst_n, rsp_valid && rsp.error, rsp.rdata == 12'd0)
	`MCID_ASSERT_SAME(a_line_range, clk, arst_n, rsp_valid && rsp.rdata[9:0] != 10'h3FF, rsp.rdata[9:7] == 3'd0)
endmodule

bind multicore_interrupt_distributor_unit mcid_checker u_mcid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
